FILE: src/sstr_pkg.sv
`timescale 1ns / 1ps
package sstr_pkg;

  localparam int CELLS_DEF = 1024;
  localparam int REQ_W     = 10;

  localparam logic [1:0] KIND_USED  = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_PICK  = 2'd3;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_RETRY = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [REQ_W-1:0] cell_req;
    logic [REQ_W-1:0] random_word;
  } in_t;

  typedef struct packed {
    logic             cell_free;
    logic [REQ_W-1:0] picked_cell;
    logic [1:0]       status;
  } out_t;

endpackage

FILE: src/sstr_ram.sv
`timescale 1ns / 1ps
module sstr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/sstr_pick.sv
`timescale 1ns / 1ps
module sstr_pick
  import sstr_pkg::*;
#(
  parameter int CELLS = CELLS_DEF
) (
  input  logic [$clog2(CELLS):0]   count,
  input  logic [REQ_W-1:0]         random_word,
  output logic [$clog2(CELLS)-1:0] addr,
  output logic                     reject
);

  localparam int CW    = $clog2(CELLS);
  localparam int CNT_W = CW + 1;

  logic [CNT_W-1:0] m_w;
  logic [CW-1:0]    m;
  logic [CW-1:0]    mask;
  logic [CW-1:0]    r;

  always_comb begin
    m_w = count - CNT_W'(1);
    m   = m_w[CW-1:0];
    for (int i = 0; i < CW; i++) begin
      mask[i] = |(m >> i);
    end
    r      = CW'(random_word) & mask;
    reject = (r > m);
    addr   = r;
  end

endmodule

FILE: src/sparse_set_free_cell_tracker_top.sv
`timescale 1ns / 1ps
// Result: an accepted request moves to S_LOOK, whose outcome is registered into out_valid and out_res.
// Mark requests that move a cell then pass through S_FIN before idle; query, pick and no-op
// marks return to idle from S_LOOK. S_FIN does the second write of the swap into both maps.
// Reset: synchronous, active low; a sweep over all CELLS entries then rewrites both maps to
// identity with busy high. Results are single-cycle strobes; the receiver cannot stall.
module sparse_set_free_cell_tracker_top
  import sstr_pkg::*;
#(
  parameter int CELLS = CELLS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_req,
  output logic out_valid,
  output out_t out_res
);

  localparam int CW    = $clog2(CELLS);
  localparam int CNT_W = CW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CLR  = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_res_r, out_res_nxt;

  logic [1:0]       kind_r;
  logic [CW-1:0]    cell_r;
  logic [CW-1:0]    pt_r;
  logic             in_range_r;
  logic             reject_r;
  logic [CW-1:0]    pos_r;
  logic [CW-1:0]    cb_r;

  logic [CW-1:0]    pick_addr;
  logic             pick_reject;
  logic [CNT_W-1:0] pt_w;
  logic             in_range_c;
  logic             accept;

  logic             cell_we, pos_we;
  logic [CW-1:0]    cell_waddr, cell_wdata, cell_raddr, cell_rd;
  logic [CW-1:0]    pos_waddr, pos_wdata, pos_raddr, pos_rd;

  logic             is_free;
  logic             do_swap;

  sstr_pick #(.CELLS(CELLS)) u_pick (
    .count       (count_r),
    .random_word (in_req.random_word),
    .addr        (pick_addr),
    .reject      (pick_reject)
  );

  sstr_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_cell_mem (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rd)
  );

  sstr_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_pos_mem (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rd)
  );

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign pt_w       = (in_req.kind == KIND_USED) ? (count_r - CNT_W'(1)) : count_r;
  assign in_range_c = (32'(in_req.cell_req) < 32'(CELLS));
  assign pos_raddr  = CW'(in_req.cell_req);
  assign cell_raddr = (in_req.kind == KIND_PICK) ? pick_addr : pt_w[CW-1:0];

  assign is_free = (CNT_W'(pos_rd) < count_r);
  assign do_swap = in_range_r &&
                   (((kind_r == KIND_USED) && is_free) ||
                    ((kind_r == KIND_FREE) && !is_free));

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_cnt_r;
    cell_wdata = clr_cnt_r;
    pos_we     = 1'b0;
    pos_waddr  = clr_cnt_r;
    pos_wdata  = clr_cnt_r;
    case (state_r)
      S_CLR: begin
        cell_we = 1'b1;
        pos_we  = 1'b1;
      end
      S_LOOK: begin
        cell_we    = do_swap;
        cell_waddr = pos_rd;
        cell_wdata = cell_rd;
        pos_we     = do_swap;
        pos_waddr  = cell_r;
        pos_wdata  = pt_r;
      end
      S_FIN: begin
        cell_we    = 1'b1;
        cell_waddr = pt_r;
        cell_wdata = cell_r;
        pos_we     = 1'b1;
        pos_waddr  = cb_r;
        pos_wdata  = pos_r;
      end
      default: begin
        cell_we = 1'b0;
        pos_we  = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + CW'(1);
        if (clr_cnt_r == CW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = '0;
        if (kind_r == KIND_PICK) begin
          if (count_r == '0) begin
            out_res_nxt.status = STAT_NONE;
          end else if (reject_r) begin
            out_res_nxt.status = STAT_RETRY;
          end else begin
            out_res_nxt.picked_cell = REQ_W'(cell_rd);
          end
        end else if (in_range_r) begin
          out_res_nxt.cell_free = is_free;
        end
        if (do_swap) begin
          count_nxt = (kind_r == KIND_USED) ? (count_r - CNT_W'(1)) : (count_r + CNT_W'(1));
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      count_r     <= CNT_W'(CELLS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (accept) begin
      kind_r     <= in_req.kind;
      cell_r     <= CW'(in_req.cell_req);
      pt_r       <= pt_w[CW-1:0];
      in_range_r <= in_range_c;
      reject_r   <= pick_reject;
    end
    if (state_r == S_LOOK) begin
      pos_r <= pos_rd;
      cb_r  <= cell_rd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CELLS))
    else $error("free count above cell total");

  a_beat_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_LOOK))
    else $error("result beat without lookup");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_FIN) |-> ($past(count_r, 2) != count_r))
    else $error("swap finished without count change");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sstr_pkg::*;

  localparam int NCELL      = CELLS_DEF;
  localparam int ITEM_GOAL  = 1650;
  localparam int STALL_MAX  = 5000;
  localparam int DRAIN_WAIT = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_req = '0;
  logic busy;
  logic out_valid;
  out_t out_res;

  sparse_set_free_cell_tracker_top #(.CELLS(NCELL)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #1 clk = ~clk;

  in_t  req_backlog[$];
  out_t results_owed[$];
  int   err_cnt = 0;
  int   n_accepted = 0;
  int   n_total = 0;
  int   stall_cnt = 0;

  logic [9:0]  slot_cell[NCELL];
  logic [9:0]  cell_slot[NCELL];
  logic [10:0] free_cnt;

  bit          gen_free[NCELL];
  int          gen_cnt;

  function automatic logic [9:0] cover_mask(logic [10:0] m);
    logic [10:0] mask;
    mask = '0;
    while (mask < m) mask = {mask[9:0], 1'b1};
    return mask[9:0];
  endfunction

  function automatic void swap_slots(logic [9:0] pa, logic [9:0] pb);
    logic [9:0] ca, cb;
    ca = slot_cell[pa];
    cb = slot_cell[pb];
    slot_cell[pa] = cb;
    slot_cell[pb] = ca;
    cell_slot[ca] = pb;
    cell_slot[cb] = pa;
  endfunction

  function automatic out_t tracker_predict(in_t req);
    out_t        res;
    logic [9:0]  pos, r;
    logic [10:0] m;
    res = '0;
    if (req.kind == KIND_PICK) begin
      if (free_cnt == 0) begin
        res.status = STAT_NONE;
      end else if (free_cnt == 1) begin
        res.picked_cell = slot_cell[0];
      end else begin
        m = free_cnt - 11'd1;
        r = req.random_word & cover_mask(m);
        if ({1'b0, r} > m) res.status = STAT_RETRY;
        else res.picked_cell = slot_cell[r];
      end
    end else begin
      pos = cell_slot[req.cell_req];
      res.cell_free = ({1'b0, pos} < free_cnt);
      if (req.kind == KIND_USED && res.cell_free) begin
        free_cnt = free_cnt - 11'd1;
        swap_slots(pos, free_cnt[9:0]);
      end else if (req.kind == KIND_FREE && !res.cell_free) begin
        swap_slots(pos, free_cnt[9:0]);
        free_cnt = free_cnt + 11'd1;
      end
    end
    return res;
  endfunction

  function automatic logic [9:0] gen_cell(bit want_free);
    logic [9:0] c;
    do c = 10'($urandom_range(NCELL - 1)); while (gen_free[c] != want_free);
    return c;
  endfunction

  function automatic void queue_req(logic [1:0] k, logic [9:0] c, logic [9:0] w);
    in_t r;
    r.kind = k;
    r.cell_req = c;
    r.random_word = w;
    req_backlog.push_back(r);
    if (k == KIND_USED && gen_free[c]) begin
      gen_free[c] = 1'b0;
      gen_cnt--;
    end else if (k == KIND_FREE && !gen_free[c]) begin
      gen_free[c] = 1'b1;
      gen_cnt++;
    end
  endfunction

  // queue a pick and retry a rejected one with fresh random bits, at most four picks in all
  function automatic void queue_pick();
    logic [9:0]  w;
    logic [10:0] m;
    int          tries;
    for (tries = 0; tries < 4; tries++) begin
      w = 10'($urandom_range(1023));
      queue_req(KIND_PICK, 10'($urandom_range(1023)), w);
      if (gen_cnt < 2) break;
      m = 11'(gen_cnt - 1);
      if ({1'b0, w & cover_mask(m)} <= m) break;
    end
  endfunction

  initial begin : stim
    int roll;
    for (int k = 0; k < NCELL; k++) begin
      slot_cell[k] = 10'(k);
      cell_slot[k] = 10'(k);
      gen_free[k] = 1'b1;
    end
    free_cnt = 11'(NCELL);
    gen_cnt = NCELL;

    queue_req(KIND_PICK, 10'd0, 10'd0);
    queue_req(KIND_PICK, 10'd1023, 10'd1023);
    queue_req(KIND_QUERY, 10'd0, 10'd1023);
    queue_req(KIND_QUERY, 10'd1023, 10'd0);
    queue_req(KIND_FREE, 10'd5, 10'd0);
    queue_req(KIND_USED, 10'd0, 10'd0);
    queue_req(KIND_USED, 10'd1023, 10'd1023);
    queue_req(KIND_USED, 10'd0, 10'd1023);
    queue_req(KIND_QUERY, 10'd0, 10'd0);
    queue_req(KIND_PICK, 10'd0, 10'd1023);
    queue_req(KIND_PICK, 10'd0, 10'd1022);
    queue_req(KIND_PICK, 10'd0, 10'd1021);
    queue_req(KIND_PICK, 10'd0, 10'd0);
    queue_req(KIND_FREE, 10'd1023, 10'd0);
    queue_req(KIND_FREE, 10'd1023, 10'd1023);
    queue_req(KIND_FREE, 10'd0, 10'd0);
    queue_req(KIND_QUERY, 10'd1023, 10'd1023);

    // drain toward an empty free set
    while (gen_cnt > 0) begin
      roll = $urandom_range(99);
      if (roll < 85) queue_req(KIND_USED, gen_cell(1'b1), 10'($urandom_range(1023)));
      else if (roll < 90) queue_pick();
      else if (roll < 94)
        queue_req(KIND_QUERY, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      else if (roll < 97)
        queue_req(KIND_FREE, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      else queue_req(KIND_USED, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
    end
    queue_pick();

    // wander around a nearly empty free set
    while (req_backlog.size() < ITEM_GOAL) begin
      roll = $urandom_range(99);
      if (roll < 30) queue_pick();
      else if (roll < 40)
        queue_req(KIND_QUERY, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      else if (roll < 68)
        queue_req(KIND_USED, gen_cnt > 0 ? gen_cell(1'b1) : 10'($urandom_range(1023)),
                  10'($urandom_range(1023)));
      else if (roll < 95) queue_req(KIND_FREE, gen_cell(1'b0), 10'($urandom_range(1023)));
      else queue_req(2'($urandom_range(1)), 10'($urandom_range(1023)),
                     10'($urandom_range(1023)));
    end
    n_total = req_backlog.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || start || results_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0 && results_owed.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    logic nxt_start;
    in_t  nxt_req;
    int   idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
    end else begin
      nxt_start = start;
      nxt_req = in_req;
      if (start && !busy) begin
        results_owed.push_back(tracker_predict(in_req));
        n_accepted++;
        nxt_start = 1'b0;
      end
      if (!nxt_start && req_backlog.size() != 0) begin
        if (n_accepted * 3 < n_total) idle_pct = 26;
        else if (n_accepted * 3 < n_total * 2) idle_pct = 79;
        else idle_pct = 0;
        if ($urandom_range(99) >= idle_pct) begin
          nxt_req = req_backlog.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
      in_req <= nxt_req;
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n && out_valid) begin
      if (results_owed.size() == 0) begin
        $error("unexpected result beat: %p", out_res);
        err_cnt++;
      end else begin
        want = results_owed.pop_front();
        if (out_res.cell_free !== want.cell_free) begin
          $error("cell_free: expected %0d, actual %0d", want.cell_free, out_res.cell_free);
          err_cnt++;
        end
        if (out_res.picked_cell !== want.picked_cell) begin
          $error("picked_cell: expected %0d, actual %0d", want.picked_cell,
                 out_res.picked_cell);
          err_cnt++;
        end
        if (out_res.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_res.status);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy && rst_n) || (out_valid && rst_n)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule

FILE: sparse_set_free_cell_tracker_top.f
src/sstr_pkg.sv
src/sstr_ram.sv
src/sstr_pick.sv
src/sparse_set_free_cell_tracker_top.sv
dv/tb_top.sv
